### rtl/buddy_block_allocator_core_assert.svh
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
`define BUDDY_BLOCK_ALLOCATOR_CORE_ASSERT_SVH
// same-cycle implication
`define BBA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define BBA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/bba_pkg.sv
// types and codes of the buddy block allocator
// no dependencies
package bba_pkg;
   typedef enum logic [1:0] {
      NODE_FREE  = 2'd0,
      NODE_SPLIT = 2'd1,
      NODE_ALLOC = 2'd2
   } node_state_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NO_SPACE  = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_EVAL,
      S_NEXT,
      S_DESC,
      S_SPLITR,
      S_MRD,
      S_MEV,
      S_DONE
   } fsm_state_type;

   localparam int KW = 5;
   localparam logic ACT_ALLOC = 1'b0;
endpackage

### rtl/buddy_block_allocator_core.sv
// buddy allocator top level: fsm, node state and owner tag memories
// depends on bba_pkg
//
// One transaction at a time. The receiver cannot stall: each result is a one-cycle rsp_valid
// strobe, and busy drops in the cycle after it. An oversized allocate goes from the accept
// straight to the result; every other request first reads and evaluates the root. Each node
// searched passes through S_READ and S_EVAL, since the node state memory read is registered.
// Each step to a sibling or back up to a parent passes through S_NEXT. An allocate that splits
// free blocks alternates S_DESC and S_SPLITR per split level and ends in S_DESC. A free tests
// each buddy for merging in S_MRD and S_MEV. Reset and a csr write empty the pool at once,
// with no clearing pass.
module buddy_block_allocator_core #(
   parameter int MAX_ORDER  = 10,
   parameter int OWNER_BITS = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic                req_action,
   input  logic [15:0]         req_request_size,
   input  logic [7:0]          req_owner_id,
   output logic                rsp_valid,
   output bba_pkg::status_type rsp_status,
   output logic [9:0]          rsp_block_offset,
   output logic [10:0]         rsp_block_size,
   input  logic                csr_write_enable,
   input  logic [3:0]          csr_write_data
);
   import bba_pkg::*;

   localparam int NW    = MAX_ORDER + 1;
   localparam int NODES = (2 ** NW) - 1;
   localparam int LW    = $clog2(MAX_ORDER + 1);

   logic [1:0]            st_mem [NODES];
   logic [OWNER_BITS-1:0] tag_mem [NODES];

   fsm_state_type state_ff, state_in;
   logic [3:0]            order_ff;
   logic                  root_ok_ff;
   logic [NW-1:0]         idx_ff;
   logic [MAX_ORDER-1:0]  pos_ff;
   logic [LW-1:0]         dep_ff, t_ff;
   logic [KW-1:0]         k_ff, k_in;
   logic [OWNER_BITS-1:0] tag_ff, tag_rd_ff;
   logic                  act_ff;
   logic [1:0]            st_rd_raw_ff;
   logic                  rd_root_ff;
   status_type            status_ff;
   logic [9:0]            off_ff;
   logic [10:0]           size_ff;

   logic                  rd_en, we, tag_we;
   logic [NW-1:0]         rd_addr, wa;
   logic [1:0]            wd;
   logic [1:0]            st_cur;
   logic [LW-1:0]         lv, t_in;
   logic                  accept, tag_hit, k_big;
   logic [31:0]           off_full, size_full;
   logic [NW-1:0]         left_idx, parent_idx, sib_idx;
   logic [15:0]           req_m1;

   assign accept     = start && !busy;
   assign lv         = t_ff - dep_ff;
   assign st_cur     = rd_root_ff ? NODE_FREE : st_rd_raw_ff;
   assign tag_hit    = tag_rd_ff == tag_ff;
   assign left_idx   = {idx_ff[NW-2:0], 1'b1};
   assign parent_idx = (idx_ff - NW'(1)) >> 1;
   assign sib_idx    = idx_ff[0] ? idx_ff + NW'(1) : idx_ff - NW'(1);
   assign off_full   = 32'(pos_ff) << lv;
   assign size_full  = 32'd1 << lv;
   assign t_in       = (32'(order_ff) > MAX_ORDER) ? LW'(MAX_ORDER) : LW'(order_ff);
   assign req_m1     = (req_request_size == 16'd0) ? 16'd0 : req_request_size - 16'd1;

   always_comb begin
      k_in = '0;
      for (int i = 0; i < 16; i++) begin
         if (req_m1[i]) k_in = KW'(i + 1);
      end
   end
   assign k_big = 32'(k_in) > 32'(t_in);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) state_in = (req_action == ACT_ALLOC && k_big) ? S_DONE : S_READ;
         end
         S_READ: state_in = S_EVAL;
         S_EVAL: begin
            if (act_ff == ACT_ALLOC) begin
               if (st_cur == NODE_ALLOC) state_in = S_NEXT;
               else if (32'(lv) == 32'(k_ff))
                  state_in = (st_cur == NODE_FREE) ? S_DONE : S_NEXT;
               else if (st_cur == NODE_FREE) state_in = S_DESC;
               else if (st_cur == NODE_SPLIT) state_in = S_READ;
               else state_in = S_NEXT;
            end else begin
               if (st_cur == NODE_ALLOC) state_in = tag_hit ? S_MRD : S_NEXT;
               else if (st_cur == NODE_SPLIT && lv != '0) state_in = S_READ;
               else state_in = S_NEXT;
            end
         end
         S_NEXT: begin
            if (idx_ff == '0) state_in = S_DONE;
            else if (!idx_ff[0]) state_in = S_NEXT;
            else state_in = S_READ;
         end
         S_DESC: state_in = (32'(lv) == 32'(k_ff)) ? S_DONE : S_SPLITR;
         S_SPLITR: state_in = S_DESC;
         S_MRD: state_in = (idx_ff == '0) ? S_DONE : S_MEV;
         S_MEV: state_in = (st_cur == NODE_FREE) ? S_MRD : S_DONE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and memory control
   always_comb begin
      busy    = state_ff != S_IDLE;
      rd_en   = 1'b0;
      rd_addr = idx_ff;
      we      = 1'b0;
      tag_we  = 1'b0;
      wa      = idx_ff;
      wd      = NODE_FREE;
      case (state_ff)
         S_READ: rd_en = 1'b1;
         S_EVAL: begin
            if (act_ff == ACT_ALLOC) begin
               if (st_cur == NODE_FREE && 32'(lv) == 32'(k_ff)) begin
                  we     = 1'b1;
                  tag_we = 1'b1;
                  wd     = NODE_ALLOC;
               end
            end else if (st_cur == NODE_ALLOC && tag_hit) begin
               we = 1'b1;
               wd = NODE_FREE;
            end
         end
         S_DESC: begin
            we = 1'b1;
            if (32'(lv) == 32'(k_ff)) begin
               tag_we = 1'b1;
               wd     = NODE_ALLOC;
            end else begin
               wd = NODE_SPLIT;
            end
         end
         S_SPLITR: begin
            we = 1'b1;
            wa = left_idx + NW'(1);
            wd = NODE_FREE;
         end
         S_MRD: begin
            rd_en   = idx_ff != '0;
            rd_addr = sib_idx;
         end
         S_MEV: begin
            we = st_cur == NODE_FREE;
            wa = parent_idx;
            wd = NODE_FREE;
         end
         default: ;
      endcase
   end

   assign rsp_valid        = state_ff == S_DONE;
   assign rsp_status       = status_ff;
   assign rsp_block_offset = off_ff;
   assign rsp_block_size   = size_ff;

   always_ff @(posedge clock) begin
      if (we) st_mem[wa] <= wd;
      if (tag_we) tag_mem[wa] <= tag_ff;
      if (rd_en) begin
         st_rd_raw_ff <= st_mem[rd_addr];
         tag_rd_ff    <= tag_mem[rd_addr];
         rd_root_ff   <= (rd_addr == '0) && !root_ok_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         order_ff   <= 4'd10;
         root_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable) begin
            order_ff   <= csr_write_data;
            root_ok_ff <= 1'b0;
         end else if (we && wa == '0) begin
            root_ok_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            act_ff    <= req_action;
            k_ff      <= k_in;
            t_ff      <= t_in;
            tag_ff    <= OWNER_BITS'(req_owner_id);
            idx_ff    <= '0;
            pos_ff    <= '0;
            dep_ff    <= '0;
            status_ff <= STATUS_NO_SPACE;
            off_ff    <= '0;
            size_ff   <= '0;
         end
         S_EVAL: begin
            if ((act_ff == ACT_ALLOC && st_cur == NODE_FREE && 32'(lv) == 32'(k_ff))
                || (act_ff != ACT_ALLOC && st_cur == NODE_ALLOC && tag_hit)) begin
               status_ff <= STATUS_DONE;
               off_ff    <= off_full[9:0];
               size_ff   <= size_full[10:0];
            end else if (state_in == S_READ) begin
               idx_ff <= left_idx;
               pos_ff <= pos_ff << 1;
               dep_ff <= dep_ff + LW'(1);
            end
         end
         S_NEXT: begin
            if (idx_ff == '0) begin
               status_ff <= (act_ff == ACT_ALLOC) ? STATUS_NO_SPACE : STATUS_NOT_FOUND;
            end else if (!idx_ff[0]) begin
               idx_ff <= parent_idx;
               pos_ff <= pos_ff >> 1;
               dep_ff <= dep_ff - LW'(1);
            end else begin
               idx_ff <= idx_ff + NW'(1);
               pos_ff <= pos_ff + MAX_ORDER'(1);
            end
         end
         S_DESC: begin
            if (32'(lv) == 32'(k_ff)) begin
               status_ff <= STATUS_DONE;
               off_ff    <= off_full[9:0];
               size_ff   <= size_full[10:0];
            end
         end
         S_SPLITR: begin
            idx_ff <= left_idx;
            pos_ff <= pos_ff << 1;
            dep_ff <= dep_ff + LW'(1);
         end
         S_MEV: begin
            if (st_cur == NODE_FREE) idx_ff <= parent_idx;
         end
         default: ;
      endcase
   end
endmodule

### rtl/bba_checker.sv
// port-level checker for buddy_block_allocator_core, with its bind
// depends on bba_pkg and buddy_block_allocator_core_assert.svh
`include "buddy_block_allocator_core_assert.svh"
module bba_checker (
   input logic                clock,
   input logic                reset,
   input logic                start,
   input logic                busy,
   input logic                rsp_valid,
   input bba_pkg::status_type rsp_status,
   input logic [9:0]          rsp_block_offset,
   input logic [10:0]         rsp_block_size
);
   import bba_pkg::*;

   `BBA_ASSERT_NOW(a_strobe_busy, clock, reset, rsp_valid, busy, "result outside transaction")
   `BBA_ASSERT_NXT(a_strobe_once, clock, reset, rsp_valid, !rsp_valid && !busy, "strobe held")
   `BBA_ASSERT_NXT(a_accept_busy, clock, reset, start && !busy, busy, "accept without busy")
   `BBA_ASSERT_NOW(a_fail_zero, clock, reset, rsp_valid && rsp_status != STATUS_DONE,
      rsp_block_offset == 10'd0 && rsp_block_size == 11'd0, "failure with payload")
endmodule

bind buddy_block_allocator_core bba_checker u_bba_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_status       (rsp_status),
   .rsp_block_offset (rsp_block_offset),
   .rsp_block_size   (rsp_block_size)
);
